// ===== design/softmax_over_channels_top_defines.svh =====
// assertion macros used by the checker file
`ifndef SOFTMAX_OVER_CHANNELS_TOP_DEFINES_SVH
`define SOFTMAX_OVER_CHANNELS_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SM_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define SM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm_pkg
// shared widths and constants for the channel softmax block
// ----------------------------------------------------------------------------
package sm_pkg;
  localparam int LOGIT_W = 16;
  localparam int PROB_W = 16;
  localparam int EXP_W = 28;
  localparam int SUM_W = 34;
  localparam int DEF_MAX_CHANNELS = 64;
  localparam int TAYLOR_TERMS = 14;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // 1/k in Q1.32 rounded up, used to divide Taylor terms by k
  function automatic logic [32:0] recip_k(input logic [3:0] k);
    logic [32:0] r;
    case (k)
      4'd1: r = 33'h1_0000_0000;
      4'd2: r = 33'd2147483648;
      4'd3: r = 33'd1431655766;
      4'd4: r = 33'd1073741824;
      4'd5: r = 33'd858993460;
      4'd6: r = 33'd715827883;
      4'd7: r = 33'd613566757;
      4'd8: r = 33'd536870912;
      4'd9: r = 33'd477218589;
      4'd10: r = 33'd429496730;
      4'd11: r = 33'd390451573;
      4'd12: r = 33'd357913942;
      4'd13: r = 33'd330382100;
      4'd14: r = 33'd306783379;
      default: r = 33'd0;
    endcase
    return r;
  endfunction
endpackage

// ===== design/softmax_over_channels_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_over_channels_top
// channel softmax: stores exp of each logit, then emits e_i / sum per channel
// ----------------------------------------------------------------------------
// channel  | dir | tdata                     | tuser
// s_axis   | in  | [15:0] logit (Q4.12)      | -
// m_axis   | out | [15:0] probability (Q0.16)| -   (tlast = last of vector)
// each logit goes from accept through 1 to 13 range reduction steps (one ln2
// per cycle), fourteen Taylor terms (multiply, 1/k multiply, correct and
// accumulate) and one store step before input is ready again
// after the last logit each probability goes through a memory read, operand
// setup, a restoring divider by the sum, and the output load
// reset clears control, fill count and sum; the exp memory is never cleared
// a stalled m_axis holds the result in the output register and stalls the
// next probability; input is taken again while the final one waits
module softmax_over_channels_top #(
  parameter int MAX_CHANNELS = sm_pkg::DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] logit
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] probability
  output logic        m_axis_tlast
);
  import sm_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RED   = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_DIVK  = 10'b0000001000,
    S_FIN   = 10'b0000010000,
    S_WR    = 10'b0000100000,
    S_RD    = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_RDW   = 10'b1000000000
  } state_t;

  state_t state;
  logic [EXP_W-1:0] mem [MAX_CHANNELS];
  logic [EXP_W-1:0] rd_data;
  logic [IDX_W-1:0] addr;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] out_idx;
  logic [SUM_W-1:0] exp_sum;
  logic             last_seen;

  // exp unit
  logic signed [36:0] xr;       // remainder during reduction
  logic signed [4:0]  n;
  logic [31:0]        r;
  logic [32:0]        term;
  logic [31:0]        tq;       // floor(term * r / 2^32), dividend of the 1/k step
  logic [36:0]        acc;
  logic [3:0]         k;
  logic [65:0]        prod;
  logic [EXP_W-1:0]   e_val;
  logic [4:0]         shift;
  logic [36:0]        rounded;

  // divider: (e<<16 + sum>>1) / sum
  logic [SUM_W+10:0]  num;
  logic [SUM_W:0]     rem;
  logic [5:0]         dcnt;
  logic [SUM_W+10:0]  quo;
  logic [SUM_W:0]     rem_sh;

  logic [SUM_W:0] sum_add;
  logic end_vec;

  assign s_axis_tready = (state == S_IDLE);
  assign shift = 5'(16 - n);
  assign rounded = (acc + (37'd1 << (shift - 5'd1))) >> shift;
  assign sum_add = {1'b0, exp_sum} + {{(SUM_W-EXP_W+1){1'b0}}, e_val};
  assign end_vec = last_seen || (fill_count == CNT_W'(MAX_CHANNELS));
  assign rem_sh = {rem[SUM_W-1:0], num[SUM_W+10]};

  always_ff @(posedge clk) begin
    if (state == S_WR) mem[fill_count[IDX_W-1:0] - IDX_W'(1)] <= e_val;
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_count <= '0;
      exp_sum <= '0;
      m_axis_tvalid <= 1'b0;
      out_idx <= '0;
      last_seen <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            xr <= 37'($signed(s_axis_tdata)) <<< 20;
            n <= '0;
            last_seen <= s_axis_tlast;
            state <= S_RED;
          end
        end
        S_RED: begin
          // reduce x into [0, ln2) one ln2 step at a time
          if (xr < 0) begin
            xr <= xr + 37'(LN2_Q32);
            n <= n - 5'sd1;
          end else if (xr >= 37'(LN2_Q32)) begin
            xr <= xr - 37'(LN2_Q32);
            n <= n + 5'sd1;
          end else begin
            r <= xr[31:0];
            term <= 33'h1_0000_0000;
            acc <= 37'h1_0000_0000;
            k <= 4'd1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= 66'(term) * 66'(r);
          state <= S_DIVK;
        end
        S_DIVK: begin
          tq <= prod[63:32];
          prod <= 66'(prod[63:32]) * 66'(recip_k(k));
          state <= S_FIN;
        end
        S_FIN: begin
          // reciprocal product may overshoot floor by one; correct
          if (33'(prod[64:32]) * 33'(k) > 33'(tq)) begin
            term <= 33'(prod[64:32]) - 33'd1;
            acc <= acc + 37'(prod[64:32]) - 37'd1;
          end else begin
            term <= 33'(prod[64:32]);
            acc <= acc + 37'(prod[64:32]);
          end
          if (k == 4'(TAYLOR_TERMS)) begin
            fill_count <= fill_count + CNT_W'(1);
            state <= S_WR;
          end else begin
            k <= k + 4'd1;
            state <= S_MUL;
          end
        end
        S_WR: begin
          // e_val is combinational from acc and n here
          exp_sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          if (end_vec) begin
            out_idx <= '0;
            addr <= '0;
            state <= S_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          num <= {1'b0, rd_data, 16'd0} + {11'd0, exp_sum >> 1};
          rem <= '0;
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, exp_sum}) begin
            rem <= rem_sh - {1'b0, exp_sum};
            quo <= {quo[SUM_W+9:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[SUM_W+9:0], 1'b0};
          end
          num <= num << 1;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(SUM_W + 10)) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= (|quo[SUM_W+10:16]) ? 16'hFFFF : quo[15:0];
            m_axis_tlast <= (out_idx + CNT_W'(1) == fill_count);
            if (out_idx + CNT_W'(1) == fill_count) begin
              fill_count <= '0;
              exp_sum <= '0;
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + CNT_W'(1);
              addr <= IDX_W'(out_idx + CNT_W'(1));
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign e_val = (|rounded[36:EXP_W]) ? EXP_MAX : rounded[EXP_W-1:0];
endmodule

// ===== design/sm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm_checker
// port-level checks for the channel softmax block
// ----------------------------------------------------------------------------
`include "softmax_over_channels_top_defines.svh"
module sm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `SM_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")
  `SM_ASSERT_NEXT(a_out_gap, clk, rst, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "results back to back")
  `SM_ASSERT_NEXT(a_in_then_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second transaction too soon")
endmodule

bind softmax_over_channels_top sm_checker u_sm_checker (.*);
